FILE: hw/rtl/cfde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cfde_pkg: shared types and constants of the text-cell draw engine
// Opcodes, store geometry and the controller/datapath command interface.
// ============================================================================
package cfde_pkg;

    localparam int MAX_COLS  = 256;
    localparam int MAX_ROWS  = 128;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int ADDR_W    = COL_W + ROW_W;
    localparam int DEPTH     = MAX_COLS * MAX_ROWS;

    localparam logic [8:0] COLS_RESET = 9'd160;
    localparam logic [7:0] ROWS_RESET = 8'd100;

    localparam logic [0:0] REG_COLS = 1'b0;
    localparam logic [0:0] REG_ROWS = 1'b1;

    typedef enum logic [2:0] {
        OP_PLOT   = 3'd0,
        OP_CIRCLE = 3'd1,
        OP_FILL   = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_READ   = 3'd4
    } opcode_t;

    // Datapath commands issued by the controller.
    typedef struct packed {
        logic load;       // capture the accepted command
        logic wr_pt;      // write the current point if inside
        logic rd_pt;      // read the current point
        logic clr_wr;     // write zero at clear address
        logic clr_step;   // advance clear address
        logic circ_sel;   // select octant point (3 bits below)
        logic [2:0] oct;
        logic circ_adv;   // dx++ and start square root
        logic sq_step;    // one square-root iteration
        logic sq_fin;     // finish rounding, update dy
        logic fill_adv;   // advance fill scan
        logic fill_init;  // start fill scan
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic circ_done;  // dy < dx
        logic sq_done;
        logic fill_done;
    } sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/cfde_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cfde_datapath: cell store, geometry registers and square-root unit
// Holds the cell memory and does all address and shape arithmetic.
// ============================================================================
module cfde_datapath (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [8:0]            cols_eff,
    input  wire logic [7:0]            rows_eff,
    input  wire logic signed [10:0]    s_pos_x,
    input  wire logic signed [10:0]    s_pos_y,
    input  wire logic [9:0]            s_extent_a,
    input  wire logic [9:0]            s_extent_b,
    input  wire logic [15:0]           s_glyph,
    input  wire logic [15:0]           s_colour,
    input  wire cfde_pkg::cmd_t        cmd,
    output cfde_pkg::sts_t             sts,
    output logic [31:0]                rd_data,
    output logic                       pt_inside
);

    logic [31:0] mem [cfde_pkg::DEPTH];

    logic signed [11:0] cx_reg, cy_reg;
    logic [9:0]  r_reg;
    logic [31:0] cell_reg;
    logic [10:0] dx_reg, dy_reg;
    logic [cfde_pkg::ADDR_W-1:0] clr_reg;
    logic [10:0] fx_reg, fy_reg, fxs_reg, fxe_reg, fye_reg;
    // Square root: remainder, result, bit.
    logic [20:0] sn_reg, sres_reg, sbit_reg;

    logic signed [12:0] px, py;
    logic [11:0] ox, oy;

    // Octant point selection.
    always_comb begin
        ox = 12'(dx_reg);
        oy = 12'(dy_reg);
        unique case (cmd.oct)
            3'd0: begin px = 13'(cx_reg) - 13'(ox); py = 13'(cy_reg) - 13'(oy); end
            3'd1: begin px = 13'(cx_reg) - 13'(oy); py = 13'(cy_reg) - 13'(ox); end
            3'd2: begin px = 13'(cx_reg) + 13'(oy); py = 13'(cy_reg) - 13'(ox); end
            3'd3: begin px = 13'(cx_reg) + 13'(ox); py = 13'(cy_reg) - 13'(oy); end
            3'd4: begin px = 13'(cx_reg) - 13'(ox); py = 13'(cy_reg) + 13'(oy); end
            3'd5: begin px = 13'(cx_reg) - 13'(oy); py = 13'(cy_reg) + 13'(ox); end
            3'd6: begin px = 13'(cx_reg) + 13'(oy); py = 13'(cy_reg) + 13'(ox); end
            default: begin px = 13'(cx_reg) + 13'(ox); py = 13'(cy_reg) + 13'(oy); end
        endcase
        if (!cmd.circ_sel) begin
            px = 13'(cx_reg);
            py = 13'(cy_reg);
        end
        if (cmd.fill_adv) begin
            px = 13'($signed({1'b0, fx_reg}));
            py = 13'($signed({1'b0, fy_reg}));
        end
    end

    assign pt_inside = (px >= 0) && (px < 13'($signed({1'b0, cols_eff})))
                    && (py >= 0) && (py < 13'($signed({1'b0, rows_eff})));

    logic [cfde_pkg::ADDR_W-1:0] pt_addr;
    assign pt_addr = {py[cfde_pkg::ROW_W-1:0], px[cfde_pkg::COL_W-1:0]};

    always_ff @(posedge aclk) begin
        if (cmd.clr_wr) begin
            mem[clr_reg] <= '0;
        end else if (cmd.wr_pt && pt_inside) begin
            mem[pt_addr] <= cell_reg;
        end
        rd_data <= mem[pt_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end
    assign sts.clr_done = &clr_reg;

    // Fill scan bounds.
    logic signed [12:0] xe_raw, ye_raw;
    assign xe_raw = 13'(s_pos_x) + 13'(s_extent_a);
    assign ye_raw = 13'(s_pos_y) + 13'(s_extent_b);

    // Square-root iteration (floor), then rounding.
    logic [20:0] sum;
    assign sum = sres_reg + sbit_reg;
    logic [21:0] r2, d2;
    assign r2 = 22'(r_reg) * 22'(r_reg);
    logic [10:0] dxn;
    assign dxn = dx_reg + 1'b1;
    assign d2 = 22'(dxn) * 22'(dxn);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cx_reg   <= 12'(s_pos_x);
            cy_reg   <= 12'(s_pos_y);
            r_reg    <= s_extent_a;
            cell_reg <= {s_colour, s_glyph};
            dx_reg   <= '0;
            dy_reg   <= 11'(s_extent_a);
            fxs_reg  <= s_pos_x < 0 ? 11'd0 : 11'(s_pos_x);
            fy_reg   <= s_pos_y < 0 ? 11'd0 : 11'(s_pos_y);
            fxe_reg  <= (xe_raw > 13'($signed({1'b0, cols_eff}))) ? 11'(cols_eff)
                      : (xe_raw < 0 ? 11'd0 : 11'(xe_raw));
            fye_reg  <= (ye_raw > 13'($signed({1'b0, rows_eff}))) ? 11'(rows_eff)
                      : (ye_raw < 0 ? 11'd0 : 11'(ye_raw));
        end
        if (cmd.fill_init) begin
            fx_reg <= fxs_reg;
        end else if (cmd.fill_adv) begin
            if (fx_reg + 1'b1 >= fxe_reg) begin
                fx_reg <= fxs_reg;
                fy_reg <= fy_reg + 1'b1;
            end else begin
                fx_reg <= fx_reg + 1'b1;
            end
        end
        if (cmd.circ_adv) begin
            dx_reg   <= dxn;
            sn_reg   <= (d2 >= r2) ? 21'd0 : 21'(r2 - d2);
            sres_reg <= '0;
            sbit_reg <= 21'h100000;
        end
        if (cmd.sq_step) begin
            if (sn_reg >= sum) begin
                sn_reg   <= sn_reg - sum;
                sres_reg <= (sres_reg >> 1) + sbit_reg;
            end else begin
                sres_reg <= sres_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
        end
        if (cmd.sq_fin) begin
            // Remainder n - s*s sits in sn_reg.
            dy_reg <= 11'(sres_reg) + ((sn_reg > sres_reg) ? 11'd1 : 11'd0);
        end
    end

    assign sts.sq_done   = (sbit_reg == '0);
    assign sts.circ_done = dy_reg < dx_reg;
    assign sts.fill_done = (fy_reg >= fye_reg) || (fxs_reg >= fxe_reg);

endmodule
`default_nettype wire

FILE: hw/rtl/cfde_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cfde_ctrl: command sequencer of the draw engine
// Accepts a command, steps the datapath through it and presents the result.
// ============================================================================
module cfde_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic [2:0]     s_opcode,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [15:0]         m_read_glyph,
    output logic [15:0]         m_read_colour,
    output logic                m_in_bounds,
    output cfde_pkg::cmd_t      cmd,
    input  wire cfde_pkg::sts_t sts,
    input  wire logic [31:0]    rd_data,
    input  wire logic           pt_inside
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_EXEC  = 9'b000000010,
        ST_READ  = 9'b000000100,
        ST_CLEAR = 9'b000001000,
        ST_OCT   = 9'b000010000,
        ST_SQRT  = 9'b000100000,
        ST_ROUND = 9'b001000000,
        ST_FILL  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] op_reg, oct_reg, oct_next;
    logic       ib_reg;
    logic [31:0] res_reg;
    // Set while the sweep that follows reset runs; that sweep gives no result.
    logic       init_reg;

    assign s_ready = (state_reg == ST_IDLE) && !m_valid;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        oct_next = oct_reg;
        cmd.oct = oct_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                priority if (op_reg == cfde_pkg::OP_PLOT) begin
                    cmd.wr_pt = 1'b1;
                    state_next = ST_OUT;
                end else if (op_reg == cfde_pkg::OP_READ) begin
                    state_next = ST_READ;
                end else if (op_reg == cfde_pkg::OP_CLEAR) begin
                    state_next = ST_CLEAR;
                end else if (op_reg == cfde_pkg::OP_CIRCLE) begin
                    oct_next = '0;
                    state_next = ST_OCT;
                end else if (op_reg == cfde_pkg::OP_FILL) begin
                    cmd.fill_init = 1'b1;
                    state_next = ST_FILL;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_READ: state_next = ST_OUT;
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                cmd.clr_step = 1'b1;
                if (sts.clr_done) state_next = init_reg ? ST_IDLE : ST_OUT;
            end
            ST_OCT: begin
                if (sts.circ_done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.circ_sel = 1'b1;
                    cmd.wr_pt = 1'b1;
                    oct_next = oct_reg + 1'b1;
                    if (oct_reg == 3'd7) begin
                        cmd.circ_adv = 1'b1;
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT: begin
                if (sts.sq_done) state_next = ST_ROUND;
                else cmd.sq_step = 1'b1;
            end
            ST_ROUND: begin
                cmd.sq_fin = 1'b1;
                state_next = ST_OCT;
            end
            ST_FILL: begin
                if (sts.fill_done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.fill_adv = 1'b1;
                    cmd.wr_pt = 1'b1;
                end
            end
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            init_reg  <= 1'b1;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR && sts.clr_done) init_reg <= 1'b0;
            if (state_reg == ST_OUT) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        oct_reg <= oct_next;
        if (cmd.load) begin
            op_reg  <= s_opcode;
            res_reg <= '0;
            ib_reg  <= 1'b0;
        end
        if (state_reg == ST_EXEC && (op_reg == cfde_pkg::OP_PLOT ||
                                     op_reg == cfde_pkg::OP_READ)) begin
            ib_reg <= pt_inside;
        end
        if (state_reg == ST_READ && ib_reg) begin
            res_reg <= rd_data;
        end
    end

    assign m_read_glyph  = res_reg[15:0];
    assign m_read_colour = res_reg[31:16];
    assign m_in_bounds   = ib_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/char_framebuffer_draw_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// char_framebuffer_draw_engine: text-cell framebuffer with shape drawing
// Top level: configuration registers, controller and datapath.
// ============================================================================
// One command beat enters on the s_ channel and exactly one result beat
// leaves on the m_ channel for it. Commands run one at a time: s_ready is
// high only while the engine is idle and no result beat waits.
// A plot passes through the execute and output states, a read through the
// execute, read and output states; with m_ready high the next command is
// accepted once the result beat is taken. A clear sweeps all 32768 cells,
// one a cycle, and gives its result after the sweep. A circle, for each dx
// step, plots the eight octant points, runs the bit-serial square root of
// r*r - dx*dx and rounds it, plus one final check, so its time grows with
// the radius. A fill writes one visible cell a cycle and then finishes.
// While m_ready is low the result register holds its beat and no command
// is taken. Reset sets the screen size to 160 by 100 and runs the same
// sweep over all 32768 cells to zero the store; s_ready stays low until it
// ends. Configuration beats set screen_cols (index 0) and screen_rows
// (index 1); cfg_ready is always high and a write acts at once, so the
// user must send it only while no command is in flight: the block itself
// does not enforce this.
// ============================================================================
module char_framebuffer_draw_engine (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_opcode,
    input  wire logic signed [10:0] s_pos_x,
    input  wire logic signed [10:0] s_pos_y,
    input  wire logic [9:0]         s_extent_a,
    input  wire logic [9:0]         s_extent_b,
    input  wire logic [15:0]        s_glyph,
    input  wire logic [15:0]        s_colour,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [15:0]             m_read_glyph,
    output logic [15:0]             m_read_colour,
    output logic                    m_in_bounds,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [8:0]         cfg_data
);

    logic [8:0] cols_reg;
    logic [7:0] rows_reg;
    logic [8:0] cols_eff;
    logic [7:0] rows_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= cfde_pkg::COLS_RESET;
            rows_reg <= cfde_pkg::ROWS_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == cfde_pkg::REG_COLS) cols_reg <= cfg_data;
            else rows_reg <= cfg_data[7:0];
        end
    end

    // Oversized registers clip to the store's geometry.
    assign cols_eff = (cols_reg > 9'(cfde_pkg::MAX_COLS)) ? 9'(cfde_pkg::MAX_COLS) : cols_reg;
    assign rows_eff = (rows_reg > 8'(cfde_pkg::MAX_ROWS)) ? 8'(cfde_pkg::MAX_ROWS) : rows_reg;

    cfde_pkg::cmd_t cmd;
    cfde_pkg::sts_t sts;
    logic [31:0]    rd_data;
    logic           pt_inside;

    cfde_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_opcode,
        .m_valid, .m_ready, .m_read_glyph, .m_read_colour, .m_in_bounds,
        .cmd, .sts, .rd_data, .pt_inside
    );

    cfde_datapath u_dp (
        .aclk, .aresetn, .cols_eff, .rows_eff,
        .s_pos_x, .s_pos_y, .s_extent_a, .s_extent_b, .s_glyph, .s_colour,
        .cmd, .sts, .rd_data, .pt_inside
    );

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for char_framebuffer_draw_engine
// Drives drawing commands and register writes, keeps a cell-accurate shadow
// of the framebuffer, checks every result beat against it or a fixed result.
// ============================================================================
module testbench;

    // A drawing command as it is driven onto the s_ channel.
    typedef struct {
        logic [2:0]         op;
        logic signed [10:0] px;
        logic signed [10:0] py;
        logic [9:0]         ea;
        logic [9:0]         eb;
        logic [15:0]        glyph;
        logic [15:0]        colour;
    } draw_cmd_t;

    // One result beat of the m_ channel.
    typedef struct {
        logic [15:0] glyph;
        logic [15:0] colour;
        logic        inb;
    } cell_result_t;

    // A row of the directed table. When fixed is set the result below is
    // the one checked, otherwise the shadow framebuffer supplies it.
    typedef struct {
        draw_cmd_t    cmd;
        bit           fixed;
        cell_result_t res;
    } directed_row_t;

    localparam int PERIOD_NS     = 4;
    localparam int WATCHDOG_MAX  = 120000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 120;
    localparam logic [2:0] OP_BAD_LO = 3'd5;
    localparam logic [2:0] OP_BAD_HI = 3'd7;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_opcode = '0;
    logic signed [10:0] s_pos_x = '0;
    logic signed [10:0] s_pos_y = '0;
    logic [9:0]         s_extent_a = '0;
    logic [9:0]         s_extent_b = '0;
    logic [15:0]        s_glyph = '0;
    logic [15:0]        s_colour = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [15:0]        m_read_glyph;
    logic [15:0]        m_read_colour;
    logic               m_in_bounds;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [0:0]         cfg_index = '0;
    logic [8:0]         cfg_data = '0;

    always #(PERIOD_NS / 2) aclk = ~aclk;

    char_framebuffer_draw_engine u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_extent_a    (s_extent_a),
        .s_extent_b    (s_extent_b),
        .s_glyph       (s_glyph),
        .s_colour      (s_colour),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_glyph  (m_read_glyph),
        .m_read_colour (m_read_colour),
        .m_in_bounds   (m_in_bounds),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Shadow framebuffer and the screen registers as the engine holds them.
    // ------------------------------------------------------------------------
    logic [31:0] shadow_cells [cfde_pkg::DEPTH];
    logic [8:0]  shadow_cols = cfde_pkg::COLS_RESET;
    logic [7:0]  shadow_rows = cfde_pkg::ROWS_RESET;

    cell_result_t pending_results[$];
    int           errors = 0;

    // Positions plotted recently, so that reads often hit drawn cells.
    int recent_x[$];
    int recent_y[$];

    // Knobs shared by the stimulus and the receiver process.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request  = 1'b0;

    function automatic int visible_cols();
        return (shadow_cols > cfde_pkg::MAX_COLS) ? cfde_pkg::MAX_COLS : int'(shadow_cols);
    endfunction

    function automatic int visible_rows();
        return (shadow_rows > cfde_pkg::MAX_ROWS) ? cfde_pkg::MAX_ROWS : int'(shadow_rows);
    endfunction

    function automatic bit on_screen(int x, int y);
        return x >= 0 && x < visible_cols() && y >= 0 && y < visible_rows();
    endfunction

    function automatic void shadow_put(int x, int y, logic [31:0] cell_word);
        if (on_screen(x, y))
            shadow_cells[y * cfde_pkg::MAX_COLS + x] = cell_word;
    endfunction

    // Nearest integer to sqrt(n), zero for a non-positive radicand.
    function automatic int nearest_root(int n);
        int s;
        int b;
        if (n <= 0)
            return 0;
        s = 0;
        for (b = 15; b >= 0; b--) begin
            if ((s + (1 << b)) * (s + (1 << b)) <= n)
                s = s + (1 << b);
        end
        if (n - s * s > s)
            s++;
        return s;
    endfunction

    function automatic void shadow_circle(int cx, int cy, int r, logic [31:0] cell_word);
        int dx;
        int dy;
        dx = 0;
        dy = r;
        while (dy >= dx) begin
            shadow_put(cx - dx, cy - dy, cell_word);
            shadow_put(cx - dy, cy - dx, cell_word);
            shadow_put(cx + dy, cy - dx, cell_word);
            shadow_put(cx + dx, cy - dy, cell_word);
            shadow_put(cx - dx, cy + dy, cell_word);
            shadow_put(cx - dy, cy + dx, cell_word);
            shadow_put(cx + dy, cy + dx, cell_word);
            shadow_put(cx + dx, cy + dy, cell_word);
            dx++;
            dy = nearest_root(r * r - dx * dx);
        end
    endfunction

    function automatic void shadow_fill(int x0, int y0, int w, int h, logic [31:0] cell_word);
        int xs;
        int ys;
        int xe;
        int ye;
        xs = (x0 < 0) ? 0 : x0;
        ys = (y0 < 0) ? 0 : y0;
        xe = x0 + w;
        ye = y0 + h;
        if (xe > visible_cols())
            xe = visible_cols();
        if (ye > visible_rows())
            ye = visible_rows();
        for (int y = ys; y < ye; y++)
            for (int x = xs; x < xe; x++)
                shadow_put(x, y, cell_word);
    endfunction

    // Applies one command to the shadow framebuffer and returns its result.
    function automatic cell_result_t draw_and_predict(draw_cmd_t c);
        cell_result_t r;
        logic [31:0]  cell_word;
        int           x;
        int           y;
        r = '{glyph: '0, colour: '0, inb: 1'b0};
        cell_word = {c.colour, c.glyph};
        x = c.px;
        y = c.py;
        case (c.op)
            cfde_pkg::OP_PLOT: begin
                r.inb = on_screen(x, y);
                shadow_put(x, y, cell_word);
                if (r.inb) begin
                    recent_x.push_back(x);
                    recent_y.push_back(y);
                    if (recent_x.size() > 64) begin
                        void'(recent_x.pop_front());
                        void'(recent_y.pop_front());
                    end
                end
            end
            cfde_pkg::OP_CIRCLE: shadow_circle(x, y, int'(c.ea), cell_word);
            cfde_pkg::OP_FILL:   shadow_fill(x, y, int'(c.ea), int'(c.eb), cell_word);
            cfde_pkg::OP_CLEAR: begin
                foreach (shadow_cells[i])
                    shadow_cells[i] = '0;
            end
            cfde_pkg::OP_READ: begin
                if (on_screen(x, y)) begin
                    r.glyph  = shadow_cells[y * cfde_pkg::MAX_COLS + x][15:0];
                    r.colour = shadow_cells[y * cfde_pkg::MAX_COLS + x][31:16];
                    r.inb    = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Command driver. It returns at the edge that accepted the beat with
    // s_valid still high, so that a back-to-back beat never lowers it.
    // ------------------------------------------------------------------------
    task automatic send_command(draw_cmd_t c, bit fixed, cell_result_t fixed_res);
        cell_result_t predicted;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_opcode   <= c.op;
        s_pos_x    <= c.px;
        s_pos_y    <= c.py;
        s_extent_a <= c.ea;
        s_extent_b <= c.eb;
        s_glyph    <= c.glyph;
        s_colour   <= c.colour;
        do @(posedge aclk); while (!s_ready);
        // The shadow is updated even for fixed rows so later rows stay right.
        predicted = draw_and_predict(c);
        pending_results.push_back(fixed ? fixed_res : predicted);
    endtask

    // Register writes happen only once every result is back and the engine
    // has had a few spare cycles to settle.
    task automatic write_screen_reg(logic [0:0] idx, logic [8:0] value);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == cfde_pkg::REG_COLS)
            shadow_cols = value;
        else
            shadow_rows = value[7:0];
    endtask

    // Mostly near the visible area, sometimes anywhere in the 11-bit range.
    function automatic logic signed [10:0] pick_coord(int span);
        if ($urandom_range(99) < 80)
            return 11'(int'($urandom_range(0, span + 8)) - 4);
        return 11'($urandom);
    endfunction

    function automatic draw_cmd_t random_command();
        draw_cmd_t c;
        int        roll;
        int        k;
        c.px     = pick_coord(visible_cols());
        c.py     = pick_coord(visible_rows());
        c.ea     = 10'($urandom);
        c.eb     = 10'($urandom);
        c.glyph  = 16'($urandom);
        c.colour = 16'($urandom);
        roll = $urandom_range(999);
        if (roll < 260) begin
            c.op = cfde_pkg::OP_PLOT;
        end else if (roll < 600) begin
            c.op = cfde_pkg::OP_READ;
            if (recent_x.size() > 0 && $urandom_range(1) == 1) begin
                k = $urandom_range(recent_x.size() - 1);
                c.px = 11'(recent_x[k]);
                c.py = 11'(recent_y[k]);
            end
        end else if (roll < 760) begin
            c.op = cfde_pkg::OP_CIRCLE;
            k = $urandom_range(99);
            if (k < 90)
                c.ea = 10'($urandom_range(30));
            else if (k < 98)
                c.ea = 10'($urandom_range(200));
        end else if (roll < 960) begin
            c.op = cfde_pkg::OP_FILL;
            k = $urandom_range(99);
            if (k < 90) begin
                c.ea = 10'($urandom_range(12));
                c.eb = 10'($urandom_range(12));
            end else if (k < 98) begin
                c.ea = 10'($urandom_range(80));
                c.eb = 10'($urandom_range(80));
            end
        end else if (roll < 970) begin
            c.op = cfde_pkg::OP_CLEAR;
        end else begin
            c.op = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off on request so
    // that the engine fills up and stalls the command channel.
    // ------------------------------------------------------------------------
    int hold_left = 0;
    bit hold_served = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_request && !hold_served) begin
            hold_served <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    // Result checker: every accepted beat is matched against the oldest
    // expectation, field by field.
    always @(posedge aclk) begin
        cell_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat arrived with no command outstanding");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_read_glyph !== want.glyph) begin
                    $error("read_glyph: expected %h, got %h", want.glyph, m_read_glyph);
                    errors++;
                end
                if (m_read_colour !== want.colour) begin
                    $error("read_colour: expected %h, got %h", want.colour, m_read_colour);
                    errors++;
                end
                if (m_in_bounds !== want.inb) begin
                    $error("in_bounds: expected %b, got %b", want.inb, m_in_bounds);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long without any beat on any channel ends the run.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------------
    directed_row_t directed[$];
    int            phase_cols [PHASES] = '{256, 511, 1, 0, 37, 160, 256};
    int            phase_rows [PHASES] = '{128, 255, 1, 0, 23, 100, 128};

    function automatic directed_row_t row(logic [2:0] op, int x, int y, int a, int b,
                                          int g, int c, bit fixed,
                                          int rg = 0, int rc = 0, bit ib = 1'b0);
        directed_row_t d;
        d.cmd = '{op: op, px: 11'(x), py: 11'(y), ea: 10'(a), eb: 10'(b),
                  glyph: 16'(g), colour: 16'(c)};
        d.fixed = fixed;
        d.res = '{glyph: 16'(rg), colour: 16'(rc), inb: ib};
        return d;
    endfunction

    initial begin
        cell_result_t none;
        none = '{glyph: '0, colour: '0, inb: 1'b0};
        foreach (shadow_cells[i])
            shadow_cells[i] = '0;

        // Reset leaves every cell zero.
        directed.push_back(row(cfde_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1));
        directed.push_back(row(cfde_pkg::OP_PLOT, 0, 0, 1023, 1023, 'hFFFF, 'hFFFF, 1, 0, 0, 1));
        directed.push_back(row(cfde_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(cfde_pkg::OP_PLOT, 159, 99, 0, 0, 'h1234, 'hABCD, 1, 0, 0, 1));
        directed.push_back(row(cfde_pkg::OP_PLOT, 160, 99, 0, 0, 'h5555, 'hAAAA, 1));
        directed.push_back(row(cfde_pkg::OP_PLOT, -1024, -1024, 0, 0, 1, 1, 1));
        directed.push_back(row(cfde_pkg::OP_PLOT, 1023, 1023, 0, 0, 2, 2, 1));
        directed.push_back(row(cfde_pkg::OP_READ, 159, 99, 0, 0, 0, 0, 0));
        directed.push_back(row(cfde_pkg::OP_READ, -1, 5, 0, 0, 0, 0, 1));
        // Radius zero touches only the centre.
        directed.push_back(row(cfde_pkg::OP_CIRCLE, 80, 50, 0, 0, 'h0041, 'h0007, 1));
        directed.push_back(row(cfde_pkg::OP_READ, 80, 50, 0, 0, 0, 0, 0));
        directed.push_back(row(cfde_pkg::OP_CIRCLE, 80, 50, 10, 0, 'h0042, 'h0003, 1));
        directed.push_back(row(cfde_pkg::OP_READ, 90, 50, 0, 0, 0, 0, 0));
        directed.push_back(row(cfde_pkg::OP_READ, 87, 43, 0, 0, 0, 0, 0));
        // The largest radius, centred at a corner, is mostly clipped.
        directed.push_back(row(cfde_pkg::OP_CIRCLE, 0, 0, 1023, 0, 'h0043, 'h0001, 1));
        directed.push_back(row(cfde_pkg::OP_FILL, 150, 90, 20, 20, 'h0023, 'h00F0, 1));
        directed.push_back(row(cfde_pkg::OP_READ, 159, 99, 0, 0, 0, 0, 0));
        // Empty rectangles draw nothing.
        directed.push_back(row(cfde_pkg::OP_FILL, 10, 10, 0, 5, 'h0001, 'h0001, 1));
        directed.push_back(row(cfde_pkg::OP_FILL, 10, 10, 5, 0, 'h0001, 'h0001, 1));
        directed.push_back(row(cfde_pkg::OP_FILL, -1024, -1024, 1023, 1023, 'h0009, 'h0009, 1));
        directed.push_back(row(cfde_pkg::OP_READ, 10, 10, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_BAD_LO, 5, 5, 1, 1, 'hFFFF, 'hFFFF, 1));
        directed.push_back(row(OP_BAD_HI, 5, 5, 1, 1, 'hFFFF, 'hFFFF, 1));
        directed.push_back(row(cfde_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 1));
        directed.push_back(row(cfde_pkg::OP_READ, 159, 99, 0, 0, 0, 0, 1, 0, 0, 1));

        // Reset is held low and released at a rising edge.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send_command(directed[i].cmd, directed[i].fixed, directed[i].res);

        for (int p = 0; p < PHASES; p++) begin
            // Idling pattern: sender light and receiver heavy, then the
            // reverse, then no idling at all.
            if (p < 2) begin
                send_idle_pct = 17;
                recv_idle_pct = 51;
            end else if (p < 4) begin
                send_idle_pct = 51;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_screen_reg(cfde_pkg::REG_COLS, 9'(phase_cols[p]));
            write_screen_reg(cfde_pkg::REG_ROWS, 9'(phase_rows[p]));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Long receiver hold-off while commands keep coming.
                if (p == 4 && n == 10)
                    hold_request = 1'b1;
                send_command(random_command(), 1'b0, none);
            end
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
